// File: hdl/vcfm_pkg.sv
// ----------------------------------------------------------------------------
// Voxel cell face mesher package
// Shared types, cell geometry tables and helper functions.
// ----------------------------------------------------------------------------
package vcfm_pkg;

  localparam int CoordW       = 16;
  localparam int SolidW       = 8;
  localparam int NumFaces     = 6;
  localparam int FaceW        = 3;
  localparam int VertsPerFace = 6;
  localparam int VertW        = 3;
  localparam int NormW        = 2;
  localparam int QueueDepth   = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [SolidW-1:0] solid_t;
  typedef logic        [NumFaces-1:0] face_mask_t;
  typedef logic        [FaceW-1:0]  face_t;
  typedef logic        [VertW-1:0]  vert_idx_t;
  typedef logic signed [NormW-1:0]  norm_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    coord_t     z;
    face_mask_t faces;
  } job_t;

  // Corner indexes of each face, in emit order of the quad.
  localparam logic [2:0] FaceCorners [NumFaces][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd2, 3'd3, 3'd7, 3'd6},
    '{3'd1, 3'd2, 3'd6, 3'd5},
    '{3'd0, 3'd3, 3'd7, 3'd4}
  };

  // Two triangles per quad: v0, v1, v2, v2, v3, v0.
  localparam logic [1:0] QuadOrder [VertsPerFace] = '{
    2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0
  };

  // Corner offsets packed as {dx, dy, dz}.
  localparam logic [2:0] CornerOff [8] = '{
    3'b000, 3'b100, 3'b110, 3'b010,
    3'b001, 3'b101, 3'b111, 3'b011
  };

  // Face normals packed as {nx, ny, nz}.
  localparam logic [3*NormW-1:0] FaceNormal [NumFaces] = '{
    6'b00_00_01, 6'b00_00_01,
    6'b00_11_00, 6'b00_01_00,
    6'b01_00_00, 6'b01_00_00
  };

  localparam vert_idx_t LastVert = vert_idx_t'(VertsPerFace - 1);

  function automatic face_mask_t qualifying_faces(solid_t solid);
    face_mask_t  mask;
    logic [3:0]  bits;
    mask = '0;
    for (int f = 0; f < NumFaces; f++) begin
      for (int c = 0; c < 4; c++) begin
        bits[c] = solid[FaceCorners[f][c]];
      end
      mask[f] = ($countones(bits) != 2);
    end
    if ((solid == '0) || (solid == '1)) begin
      mask = '0;
    end
    return mask;
  endfunction

  function automatic face_t first_face(face_mask_t mask);
    face_t f;
    f = '0;
    for (int i = NumFaces - 1; i >= 0; i--) begin
      if (mask[i]) begin
        f = face_t'(i);
      end
    end
    return f;
  endfunction

endpackage

// File: hdl/vcfm_if.sv
// ----------------------------------------------------------------------------
// Voxel cell face mesher channels
// Valid/ready channels for input cells and output vertices.
// ----------------------------------------------------------------------------
interface vcfm_cell_if;
  import vcfm_pkg::*;

  logic   valid;
  logic   ready;
  coord_t cell_x;
  coord_t cell_y;
  coord_t cell_z;
  solid_t corner_solid;

  modport source (output valid, output cell_x, output cell_y, output cell_z,
                  output corner_solid, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input cell_z,
                  input corner_solid, output ready);
endinterface

interface vcfm_vert_if;
  import vcfm_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vert_x;
  coord_t vert_y;
  coord_t vert_z;
  norm_t  normal_x;
  norm_t  normal_y;
  norm_t  normal_z;
  face_t  face_number;
  logic   last_vertex;

  modport source (output valid, output vert_x, output vert_y, output vert_z,
                  output normal_x, output normal_y, output normal_z,
                  output face_number, output last_vertex, input ready);
  modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                  input normal_x, input normal_y, input normal_z,
                  input face_number, input last_vertex, output ready);
endinterface

// File: hdl/vcfm_front.sv
// ----------------------------------------------------------------------------
// Voxel cell face mesher front end
// Accepts cells, finds the faces that emit, and drops cells with none.
// ----------------------------------------------------------------------------
module vcfm_front (
  vcfm_cell_if.sink      cell_i,
  output logic           push_o,
  output vcfm_pkg::job_t job_o,
  input  logic           room_i
);
  import vcfm_pkg::*;

  face_mask_t faces;

  assign faces        = qualifying_faces(cell_i.corner_solid);
  assign cell_i.ready = room_i;
  assign push_o       = cell_i.valid && room_i && (faces != '0);

  assign job_o.x     = cell_i.cell_x;
  assign job_o.y     = cell_i.cell_y;
  assign job_o.z     = cell_i.cell_z;
  assign job_o.faces = faces;

endmodule

// File: hdl/vcfm_queue.sv
// ----------------------------------------------------------------------------
// Voxel cell face mesher job queue
// Small FIFO of classified cells between the front and back ends.
// ----------------------------------------------------------------------------
module vcfm_queue #(
  parameter int Depth = vcfm_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vcfm_pkg::job_t job_i,
  output logic           room_o,
  output logic           valid_o,
  output vcfm_pkg::job_t job_o,
  input  logic           pop_i
);
  import vcfm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign room_o  = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// File: hdl/vcfm_back.sv
// ----------------------------------------------------------------------------
// Voxel cell face mesher back end
// Walks the qualifying faces of one cell and emits six vertices per face.
// ----------------------------------------------------------------------------
module vcfm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  vcfm_pkg::job_t job_i,
  output logic           pop_o,
  vcfm_vert_if.source    vert_o
);
  import vcfm_pkg::*;

  logic       busy_q, busy_d;
  coord_t     x_q, y_q, z_q;
  face_mask_t rem_q, rem_d;
  vert_idx_t  k_q, k_d;
  logic       out_valid_q;

  face_t      face;
  face_mask_t rem_clr;
  logic       adv;
  logic       face_done;
  logic       last;
  logic [2:0] corner;
  logic [2:0] off;

  assign face      = first_face(rem_q);
  assign rem_clr   = rem_q & ~(face_mask_t'(1) << face);
  assign adv       = busy_q && (!out_valid_q || vert_o.ready);
  assign face_done = (k_q == LastVert);
  assign last      = face_done && (rem_clr == '0);
  assign pop_o     = valid_i && (!busy_q || (adv && last));
  assign corner    = FaceCorners[face][QuadOrder[k_q]];
  assign off       = CornerOff[corner];

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    k_d    = k_q;
    if (adv) begin
      if (face_done) begin
        k_d   = '0;
        rem_d = rem_clr;
        if (last) begin
          busy_d = 1'b0;
        end
      end else begin
        k_d = k_q + 1'b1;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      rem_d  = job_i.faces;
      k_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      k_q    <= k_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (vert_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q <= job_i.x;
      y_q <= job_i.y;
      z_q <= job_i.z;
    end
    if (adv) begin
      vert_o.vert_x      <= x_q + coord_t'(off[2]);
      vert_o.vert_y      <= y_q + coord_t'(off[1]);
      vert_o.vert_z      <= z_q + coord_t'(off[0]);
      vert_o.normal_x    <= FaceNormal[face][3*NormW-1:2*NormW];
      vert_o.normal_y    <= FaceNormal[face][2*NormW-1:NormW];
      vert_o.normal_z    <= FaceNormal[face][NormW-1:0];
      vert_o.face_number <= face;
      vert_o.last_vertex <= last;
    end
  end

  assign vert_o.valid = out_valid_q;

endmodule

// File: hdl/voxel_cell_face_mesher_top.sv
// ----------------------------------------------------------------------------
// Voxel cell face mesher top level
// Front end, job queue and back end of the cell face mesher.
// ----------------------------------------------------------------------------
// Each cell beat gives six vertex beats for every face that has other than
// two solid corners, with last_vertex set on the final one; cells that are
// uniform or have no such face give no vertex beat. The front end takes one
// cell beat per cycle while the job queue has room; cells without output are
// dropped there. The back end emits one vertex per cycle from its output
// register while the sink is ready, 6 * n vertices for a cell with n emitting
// faces (at most 36), with no gap between cells; the first vertex of a cell
// passes through the job queue, the back end's job state and output register.
module voxel_cell_face_mesher_top #(
  parameter int QueueDepth = vcfm_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vcfm_cell_if.sink   cell_i,
  vcfm_vert_if.source vert_o
);
  import vcfm_pkg::*;

  logic push;
  logic room;
  logic job_valid;
  logic pop;
  job_t job_in;
  job_t job_out;

  vcfm_front u_front (
    .cell_i (cell_i),
    .push_o (push),
    .job_o  (job_in),
    .room_i (room)
  );

  vcfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .room_o  (room),
    .valid_o (job_valid),
    .job_o   (job_out),
    .pop_i   (pop)
  );

  vcfm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_valid),
    .job_i   (job_out),
    .pop_o   (pop),
    .vert_o  (vert_o)
  );

endmodule

// File: tb/tb_voxel_cell_face_mesher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel cell face mesher testbench
// Sends grid cells over the cell channel, predicts the vertex stream of each
// cell from the corner bits, and compares every vertex beat in order.
// ----------------------------------------------------------------------------
module tb_voxel_cell_face_mesher_top;
  import vcfm_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int IdlePercent = 20;
  localparam int MaxPrinted  = 30;

  // Corners of each face and the corner pick of the two triangles.
  localparam int MeshFaceCorner [6][4] = '{
    '{0, 1, 2, 3}, '{4, 5, 6, 7}, '{0, 1, 5, 4},
    '{2, 3, 7, 6}, '{1, 2, 6, 5}, '{0, 3, 7, 4}
  };
  localparam int TriCornerPick [6] = '{0, 1, 2, 2, 3, 0};
  localparam int CornerDx [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
  localparam int CornerDy [8] = '{0, 0, 1, 1, 0, 0, 1, 1};
  localparam int CornerDz [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
  localparam int FaceNx [6] = '{0, 0, 0, 0, 1, 1};
  localparam int FaceNy [6] = '{0, 0, -1, 1, 0, 0};
  localparam int FaceNz [6] = '{1, 1, 0, 0, 0, 0};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    norm_t  nx;
    norm_t  ny;
    norm_t  nz;
    face_t  face;
    logic   last;
  } mesh_vert_t;

  logic clk;
  logic rst_n;
  logic idle_on;
  int   mismatches;
  int   cells_sent;
  int   quiet_cells;
  int   verts_checked;
  int   stall_cycles;

  mesh_vert_t expected_verts[$];

  vcfm_cell_if cell_ch ();
  vcfm_vert_if vert_ch ();

  voxel_cell_face_mesher_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cell_i(cell_ch),
    .vert_o(vert_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic coord_t rand_coord();
    return coord_t'(int'($urandom_range(0, 65534)) - 32768);
  endfunction

  // Appends the vertex stream that one cell should give to the queue.
  function automatic int predict_cell_mesh(coord_t x, coord_t y, coord_t z, solid_t solid);
    logic [3:0] face_bits;
    logic [5:0] emitting;
    int         last_face;
    int         corner;
    int         count;
    mesh_vert_t v;
    emitting  = '0;
    last_face = -1;
    count     = 0;
    if ((solid == 8'h00) || (solid == 8'hFF)) begin
      return 0;
    end
    for (int f = 0; f < 6; f++) begin
      for (int c = 0; c < 4; c++) begin
        face_bits[c] = solid[MeshFaceCorner[f][c]];
      end
      if ($countones(face_bits) != 2) begin
        emitting[f] = 1'b1;
        last_face   = f;
      end
    end
    for (int f = 0; f < 6; f++) begin
      if (emitting[f]) begin
        for (int k = 0; k < 6; k++) begin
          corner = MeshFaceCorner[f][TriCornerPick[k]];
          v.x    = x + coord_t'(CornerDx[corner]);
          v.y    = y + coord_t'(CornerDy[corner]);
          v.z    = z + coord_t'(CornerDz[corner]);
          v.nx   = norm_t'(FaceNx[f]);
          v.ny   = norm_t'(FaceNy[f]);
          v.nz   = norm_t'(FaceNz[f]);
          v.face = face_t'(f);
          v.last = (f == last_face) && (k == 5);
          expected_verts = {expected_verts, v};
          count++;
        end
      end
    end
    return count;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic send_cell(coord_t x, coord_t y, coord_t z, solid_t solid);
    @(negedge clk);
    while (idle_on && ($urandom_range(0, 99) < IdlePercent)) begin
      cell_ch.valid = 1'b0;
      @(negedge clk);
    end
    cell_ch.valid        = 1'b1;
    cell_ch.cell_x       = x;
    cell_ch.cell_y       = y;
    cell_ch.cell_z       = z;
    cell_ch.corner_solid = solid;
    @(posedge clk);
    while (!cell_ch.ready) begin
      @(posedge clk);
    end
    if (predict_cell_mesh(x, y, z, solid) == 0) begin
      quiet_cells++;
    end
    cells_sent++;
  endtask

  task automatic test_directed_cells();
    idle_on = 1'b1;
    send_cell(16'sd0, 16'sd0, 16'sd0, 8'h00);
    send_cell(16'sd5, -16'sd7, 16'sd9, 8'hFF);
    send_cell(-16'sd32768, -16'sd32768, -16'sd32768, 8'h01);
    send_cell(16'sd32766, 16'sd32766, 16'sd32766, 8'h80);
    send_cell(16'sd32766, -16'sd32768, 16'sd0, 8'hFE);
    send_cell(-16'sd1, -16'sd1, -16'sd1, 8'h7F);
    send_cell(16'sd100, 16'sd200, 16'sd300, 8'hA5);
    send_cell(-16'sd100, 16'sd200, -16'sd300, 8'h5A);
    send_cell(16'sd1, 16'sd2, 16'sd3, 8'h0F);
    send_cell(16'sd4, 16'sd5, 16'sd6, 8'hF0);
    send_cell(16'sd7, 16'sd8, 16'sd9, 8'h66);
    send_cell(16'sd10, 16'sd11, 16'sd12, 8'h99);
    send_cell(16'sd13, 16'sd14, 16'sd15, 8'h33);
    for (int b = 0; b < 8; b++) begin
      send_cell(rand_coord(), rand_coord(), rand_coord(), solid_t'(8'h01 << b));
    end
    send_cell(16'sd32766, 16'sd32766, 16'sd32766, 8'h3C);
  endtask

  task automatic test_random_cells(int n, logic with_idle);
    solid_t solid;
    idle_on = with_idle;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       solid = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        1:       solid = ($urandom_range(0, 1) != 0) ? 8'hA5 : 8'h5A;
        default: solid = solid_t'($urandom_range(1, 254));
      endcase
      send_cell(rand_coord(), rand_coord(), rand_coord(), solid);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      vert_ch.ready = 1'b0;
    end else begin
      vert_ch.ready = !idle_on || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  always @(posedge clk) begin
    mesh_vert_t want;
    if (rst_n && vert_ch.valid && vert_ch.ready) begin
      if (expected_verts.size() == 0) begin
        report_mismatch($sformatf("vertex beat (%0d,%0d,%0d) with nothing expected",
                                  vert_ch.vert_x, vert_ch.vert_y, vert_ch.vert_z));
      end else begin
        want = expected_verts.pop_front();
        if (vert_ch.vert_x !== want.x)
          report_mismatch($sformatf("vertex %0d vert_x got %0d want %0d",
                                    verts_checked, vert_ch.vert_x, want.x));
        if (vert_ch.vert_y !== want.y)
          report_mismatch($sformatf("vertex %0d vert_y got %0d want %0d",
                                    verts_checked, vert_ch.vert_y, want.y));
        if (vert_ch.vert_z !== want.z)
          report_mismatch($sformatf("vertex %0d vert_z got %0d want %0d",
                                    verts_checked, vert_ch.vert_z, want.z));
        if (vert_ch.normal_x !== want.nx)
          report_mismatch($sformatf("vertex %0d normal_x got %0d want %0d",
                                    verts_checked, vert_ch.normal_x, want.nx));
        if (vert_ch.normal_y !== want.ny)
          report_mismatch($sformatf("vertex %0d normal_y got %0d want %0d",
                                    verts_checked, vert_ch.normal_y, want.ny));
        if (vert_ch.normal_z !== want.nz)
          report_mismatch($sformatf("vertex %0d normal_z got %0d want %0d",
                                    verts_checked, vert_ch.normal_z, want.nz));
        if (vert_ch.face_number !== want.face)
          report_mismatch($sformatf("vertex %0d face_number got %0d want %0d",
                                    verts_checked, vert_ch.face_number, want.face));
        if (vert_ch.last_vertex !== want.last)
          report_mismatch($sformatf("vertex %0d last_vertex got %b want %b",
                                    verts_checked, vert_ch.last_vertex, want.last));
      end
      verts_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cell_ch.valid && cell_ch.ready) || (vert_ch.valid && vert_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Watchdog: no beat for %0d cycles, %0d vertices outstanding",
               StallLimit, expected_verts.size());
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n                = 1'b0;
    idle_on              = 1'b1;
    mismatches           = 0;
    cells_sent           = 0;
    quiet_cells          = 0;
    verts_checked        = 0;
    stall_cycles         = 0;
    cell_ch.valid        = 1'b0;
    cell_ch.cell_x       = '0;
    cell_ch.cell_y       = '0;
    cell_ch.cell_z       = '0;
    cell_ch.corner_solid = '0;
    vert_ch.ready        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cells();
    test_random_cells(120, 1'b1);
    test_random_cells(45, 1'b0);
    test_random_cells(25, 1'b1);

    @(negedge clk);
    cell_ch.valid = 1'b0;
    while (expected_verts.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Meshed %0d cells (%0d without any face) and checked %0d vertex beats.",
             cells_sent, quiet_cells, verts_checked);
    $display("Random gaps on both channels, plus one stretch at full rate; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/vcfm_pkg.sv
hdl/vcfm_if.sv
hdl/vcfm_front.sv
hdl/vcfm_queue.sv
hdl/vcfm_back.sv
hdl/voxel_cell_face_mesher_top.sv
tb/tb_voxel_cell_face_mesher_top.sv
